// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/mtpe_pkg.sv =====
// Types, constants and functions of the Merkle tree proof engine
`timescale 1ns / 1ps
package mtpe_pkg;
    typedef enum logic [1:0] {
        ACT_BUILD  = 2'd0,
        ACT_PROVE  = 2'd1,
        ACT_VERIFY = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LEAF_START,
        ST_LEAF_WAIT,
        ST_LEAF_WR,
        ST_NODE_RD,
        ST_NODE_CAP,
        ST_NODE_WAIT,
        ST_NODE_WR,
        ST_ROOT_RD,
        ST_ROOT_CAP,
        ST_PROVE_RD,
        ST_PROVE_CAP,
        ST_PROVE_OUT,
        ST_VLEAF_WAIT,
        ST_VSTORE,
        ST_VFOLD_WAIT,
        ST_VCMP_RD,
        ST_VCMP_CAP,
        ST_OUT
    } state_t;

    localparam int unsigned ROUNDS = 7;
    localparam logic [31:0] FLAGS_ROOT = 32'd11;
    localparam logic [31:0] LEN_LEAF = 32'd36;
    localparam logic [31:0] LEN_PAIR = 32'd64;

    typedef struct packed {
        logic         start;
        logic [511:0] msg;
        logic [31:0]  block_len;
    } hash_req_t;

    typedef struct packed {
        logic         done;
        logic [255:0] digest;
    } hash_rsp_t;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] w;
        case (i)
            3'd0: w = 32'h6A09E667;
            3'd1: w = 32'hBB67AE85;
            3'd2: w = 32'h3C6EF372;
            3'd3: w = 32'hA54FF53A;
            3'd4: w = 32'h510E527F;
            3'd5: w = 32'h9B05688C;
            3'd6: w = 32'h1F83D9AB;
            default: w = 32'h5BE0CD19;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] perm_idx(input logic [3:0] i);
        logic [3:0] p;
        case (i)
            4'd0: p = 4'd2;   4'd1: p = 4'd6;   4'd2: p = 4'd3;   4'd3: p = 4'd10;
            4'd4: p = 4'd7;   4'd5: p = 4'd0;   4'd6: p = 4'd4;   4'd7: p = 4'd13;
            4'd8: p = 4'd1;   4'd9: p = 4'd11;  4'd10: p = 4'd12; 4'd11: p = 4'd5;
            4'd12: p = 4'd9;  4'd13: p = 4'd14; 4'd14: p = 4'd15; default: p = 4'd8;
        endcase
        return p;
    endfunction
endpackage

// ===== hdl/merkle_tree_proof_engine.sv =====
// Top level: node store, build/prove/verify sequencer, APB registers
//
// channel  | dir | contents
// s_axis   | in  | tdata {proof_word, leaf_index, action}, tlast proof_last
// m_axis   | out | tdata out_word, tuser proof_ok, tlast out_last
// apb      | in  | seed_word_0..3 at 0x00, 0x08, 0x10, 0x18
//
// Each hash runs in the shared compression unit (7 rounds, 2 steps each).
// Build: each leaf is hashed and stored, then each inner node (8 paired reads), then the root is emitted.
// Prove: one read of the one-port node store per output word; a verify word is stored and every
// fourth word folds the running hash, with a root compare after the last word.
// The node store is one 64-bit memory with registered read; it needs no clearing.
// Reset clears control state and the verify hash buffers; m_axis backpressure stalls the sequencer.
`timescale 1ns / 1ps
module merkle_tree_proof_engine #(
    parameter int unsigned LEAF_COUNT = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // action[1:0], leaf_index[11:2], proof_word[75:12]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // out_word[63:0]
    output logic         m_axis_tuser,   // proof_ok
    output logic         m_axis_tlast
);
    import mtpe_pkg::*;

    localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT - 1;
    localparam int unsigned NW = $clog2(NODE_COUNT);
    localparam int unsigned LW = $clog2(LEAF_COUNT);
    localparam int unsigned AW = NW + 2;

    logic [63:0] seed_reg [4];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                seed_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0)
        begin
            seed_reg[paddr[4:3]] <= pwdata;
        end
    end
    assign pready = 1'b1;
    assign prdata = seed_reg[paddr[4:3]];

    logic [63:0] mem [4 * NODE_COUNT];
    logic [AW-1:0] maddr;
    logic          mwe;
    logic [63:0]   mwdata, mrdata;
    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            mem[maddr] <= mwdata;
        end
        mrdata <= mem[maddr];
    end

    hash_req_t hreq;
    hash_rsp_t hrsp;
    mtpe_hash u_hash (.clk(clk), .rst_n(rst_n), .req(hreq), .rsp(hrsp));

    state_t        state_reg, state_next;
    logic [NW-1:0] node_reg, node_next;
    logic [1:0]    wc_reg, wc_next;
    logic [3:0]    sub_reg, sub_next;
    logic [255:0]  hbuf_reg, hbuf_next;
    logic [255:0]  lbuf_reg, lbuf_next;
    logic [255:0]  run_reg, run_next;
    logic [255:0]  sib_reg, sib_next;
    logic [NW-1:0] vpos_reg, vpos_next;
    logic [1:0]    vwc_reg, vwc_next;
    logic          inprog_reg, inprog_next;
    logic          last_reg, last_next;
    logic          ok_reg, ok_next;
    logic          otv_reg, otv_next;
    logic [63:0]   ow_reg, ow_next;
    logic          ol_reg, ol_next;
    logic          ook_reg, ook_next;

    logic [1:0]    in_action;
    logic [LW-1:0] in_leaf;
    logic [63:0]   in_word;
    assign in_action = s_axis_tdata[1:0];
    assign in_leaf   = LW'(s_axis_tdata[11:2]);
    assign in_word   = s_axis_tdata[75:12];

    logic out_free;
    assign out_free = !otv_reg || m_axis_tready;

    function automatic logic [511:0] leaf_msg(input logic [63:0] s0, s1, s2, s3,
                                              input logic [31:0] idx);
        return {224'd0, idx, s3, s2, s1, s0};
    endfunction

    always_comb
    begin
        logic [NW-1:0] leafnode;
        logic [NW-1:0] sib;
        state_next  = state_reg;
        node_next   = node_reg;
        wc_next     = wc_reg;
        sub_next    = sub_reg;
        hbuf_next   = hbuf_reg;
        lbuf_next   = lbuf_reg;
        run_next    = run_reg;
        sib_next    = sib_reg;
        vpos_next   = vpos_reg;
        vwc_next    = vwc_reg;
        inprog_next = inprog_reg;
        last_next   = last_reg;
        ok_next     = ok_reg;
        otv_next    = otv_reg && !m_axis_tready;
        ow_next     = ow_reg;
        ol_next     = ol_reg;
        ook_next    = ook_reg;
        maddr       = '0;
        mwe         = 1'b0;
        mwdata      = '0;
        hreq        = '0;
        s_axis_tready = 1'b0;
        leafnode    = NW'(LEAF_COUNT - 1) + NW'(in_leaf);
        sib         = node_reg[0] ? node_reg + NW'(1) : node_reg - NW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    case (in_action)
                        ACT_BUILD:
                        begin
                            node_next  = NW'(LEAF_COUNT - 1);
                            state_next = ST_LEAF_START;
                        end
                        ACT_PROVE:
                        begin
                            node_next  = leafnode;
                            wc_next    = '0;
                            state_next = ST_PROVE_RD;
                        end
                        ACT_VERIFY:
                        begin
                            sib_next[64 * vwc_reg +: 64] = in_word;
                            last_next = s_axis_tlast;
                            if (!inprog_reg)
                            begin
                                vpos_next   = leafnode;
                                inprog_next = 1'b1;
                                sib_next[63:0] = in_word;
                                vwc_next    = 2'd1;
                                hreq.start  = 1'b1;
                                hreq.msg    = leaf_msg(seed_reg[0], seed_reg[1], seed_reg[2],
                                                       seed_reg[3], 32'(in_leaf));
                                hreq.block_len = LEN_LEAF;
                                state_next  = ST_VLEAF_WAIT;
                            end
                            else
                            begin
                                vwc_next   = vwc_reg + 2'd1;
                                state_next = ST_VSTORE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LEAF_START:
            begin
                hreq.start = 1'b1;
                hreq.msg   = leaf_msg(seed_reg[0], seed_reg[1], seed_reg[2], seed_reg[3],
                                      32'(node_reg - NW'(LEAF_COUNT - 1)));
                hreq.block_len = LEN_LEAF;
                state_next = ST_LEAF_WAIT;
            end
            ST_LEAF_WAIT:
            begin
                if (hrsp.done)
                begin
                    hbuf_next  = hrsp.digest;
                    sub_next   = '0;
                    state_next = ST_LEAF_WR;
                end
            end
            ST_LEAF_WR:
            begin
                mwe    = 1'b1;
                maddr  = {node_reg, sub_reg[1:0]};
                mwdata = hbuf_reg[64 * sub_reg[1:0] +: 64];
                sub_next = sub_reg + 4'd1;
                if (sub_reg[1:0] == 2'd3)
                begin
                    if (node_reg == NW'(NODE_COUNT - 1))
                    begin
                        node_next  = NW'(LEAF_COUNT - 2);
                        sub_next   = '0;
                        state_next = ST_NODE_RD;
                    end
                    else
                    begin
                        node_next  = node_reg + NW'(1);
                        state_next = ST_LEAF_START;
                    end
                end
            end
            ST_NODE_RD:
            begin
                maddr = {NW'(2) * node_reg + NW'(1), 2'b00} + AW'(sub_reg[2:0]);
                state_next = ST_NODE_CAP;
            end
            ST_NODE_CAP:
            begin
                if (!sub_reg[2]) lbuf_next = {mrdata, lbuf_reg[255:64]};
                if (sub_reg[2]) hbuf_next = {mrdata, hbuf_reg[255:64]};
                sub_next = sub_reg + 4'd1;
                if (sub_reg[2:0] == 3'd7)
                begin
                    state_next = ST_NODE_WAIT;
                    hreq.start = 1'b1;
                end
                else
                begin
                    state_next = ST_NODE_RD;
                end
                if (sub_reg[2])
                begin
                    hreq.msg = {mrdata, hbuf_reg[255:64], lbuf_reg};
                end
                else
                begin
                    hreq.msg = '0;
                end
                hreq.block_len = LEN_PAIR;
            end
            ST_NODE_WAIT:
            begin
                if (hrsp.done)
                begin
                    hbuf_next  = hrsp.digest;
                    sub_next   = '0;
                    state_next = ST_NODE_WR;
                end
            end
            ST_NODE_WR:
            begin
                mwe    = 1'b1;
                maddr  = {node_reg, sub_reg[1:0]};
                mwdata = hbuf_reg[64 * sub_reg[1:0] +: 64];
                sub_next = sub_reg + 4'd1;
                if (sub_reg[1:0] == 2'd3)
                begin
                    sub_next = '0;
                    if (node_reg == '0)
                    begin
                        state_next = ST_ROOT_RD;
                    end
                    else
                    begin
                        node_next  = node_reg - NW'(1);
                        state_next = ST_NODE_RD;
                    end
                end
            end
            ST_ROOT_RD:
            begin
                maddr = AW'(sub_reg[1:0]);
                state_next = ST_ROOT_CAP;
            end
            ST_ROOT_CAP:
            begin
                maddr = AW'(sub_reg[1:0]);
                if (out_free)
                begin
                    otv_next = 1'b1;
                    ow_next  = mrdata;
                    ol_next  = sub_reg[1:0] == 2'd3;
                    ook_next = 1'b0;
                    sub_next = sub_reg + 4'd1;
                    state_next = (sub_reg[1:0] == 2'd3) ? ST_IDLE : ST_ROOT_RD;
                end
            end
            ST_PROVE_RD:
            begin
                if (node_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    maddr = {sib, wc_reg};
                    state_next = ST_PROVE_CAP;
                end
            end
            ST_PROVE_CAP:
            begin
                hbuf_next[63:0] = mrdata;
                state_next = ST_PROVE_OUT;
            end
            ST_PROVE_OUT:
            begin
                if (out_free)
                begin
                    otv_next = 1'b1;
                    ow_next  = hbuf_reg[63:0];
                    ol_next  = (wc_reg == 2'd3) && (node_reg <= NW'(2));
                    ook_next = 1'b0;
                    wc_next  = wc_reg + 2'd1;
                    if (wc_reg == 2'd3)
                    begin
                        node_next = (node_reg - NW'(1)) >> 1;
                    end
                    state_next = ST_PROVE_RD;
                end
            end
            ST_VLEAF_WAIT:
            begin
                if (hrsp.done)
                begin
                    run_next   = hrsp.digest;
                    state_next = ST_VSTORE;
                end
            end
            ST_VSTORE:
            begin
                if (vwc_reg == 2'd0)
                begin
                    hreq.start = 1'b1;
                    hreq.msg   = vpos_reg[0] ? {sib_reg, run_reg} : {run_reg, sib_reg};
                    hreq.block_len = LEN_PAIR;
                    state_next = ST_VFOLD_WAIT;
                end
                else
                begin
                    state_next = last_reg ? ST_VCMP_RD : ST_IDLE;
                    sub_next   = '0;
                end
            end
            ST_VFOLD_WAIT:
            begin
                if (hrsp.done)
                begin
                    run_next = hrsp.digest;
                    if (vpos_reg != '0)
                    begin
                        vpos_next = (vpos_reg - NW'(1)) >> 1;
                    end
                    sub_next   = '0;
                    state_next = last_reg ? ST_VCMP_RD : ST_IDLE;
                end
            end
            ST_VCMP_RD:
            begin
                maddr = AW'(sub_reg[1:0]);
                state_next = ST_VCMP_CAP;
            end
            ST_VCMP_CAP:
            begin
                if (sub_reg[1:0] == 2'd0)
                begin
                    ok_next = mrdata == run_reg[63:0];
                end
                else
                begin
                    ok_next = ok_reg && (mrdata == run_reg[64 * sub_reg[1:0] +: 64]);
                end
                sub_next = sub_reg + 4'd1;
                state_next = (sub_reg[1:0] == 2'd3) ? ST_OUT : ST_VCMP_RD;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    otv_next    = 1'b1;
                    ow_next     = '0;
                    ol_next     = 1'b1;
                    ook_next    = ok_reg;
                    inprog_next = 1'b0;
                    vwc_next    = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vwc_reg    <= '0;
            inprog_reg <= 1'b0;
            otv_reg    <= 1'b0;
            vpos_reg   <= '0;
            run_reg    <= '0;
            sib_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            vwc_reg    <= vwc_next;
            inprog_reg <= inprog_next;
            otv_reg    <= otv_next;
            vpos_reg   <= vpos_next;
            run_reg    <= run_next;
            sib_reg    <= sib_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        wc_reg   <= wc_next;
        sub_reg  <= sub_next;
        hbuf_reg <= hbuf_next;
        lbuf_reg <= lbuf_next;
        last_reg <= last_next;
        ok_reg   <= ok_next;
        ow_reg   <= ow_next;
        ol_reg   <= ol_next;
        ook_reg  <= ook_next;
    end

    assign m_axis_tvalid = otv_reg;
    assign m_axis_tdata  = ow_reg;
    assign m_axis_tuser  = ook_reg;
    assign m_axis_tlast  = ol_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_ok_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    `ASSERT_IMPLIES(a_wr_build, clk, rst_n, mwe,
                    state_reg == ST_LEAF_WR || state_reg == ST_NODE_WR)
endmodule

// ===== hdl/mtpe_hash.sv =====
// BLAKE3 single block compression, one G column or diagonal step per cycle
`timescale 1ns / 1ps
module mtpe_hash (
    input  logic                clk,
    input  logic                rst_n,
    input  mtpe_pkg::hash_req_t req,
    output mtpe_pkg::hash_rsp_t rsp
);
    import mtpe_pkg::*;

    logic [15:0][31:0] v_reg, v_next;
    logic [15:0][31:0] m_reg, m_next;
    logic [2:0]        round_reg, round_next;
    logic              half_reg, half_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    function automatic logic [127:0] gmix(input logic [31:0] a, b, c, d, x, y);
        logic [31:0] a1, b1, c1, d1;
        a1 = a + b + x;
        d1 = d ^ a1; d1 = {d1[15:0], d1[31:16]};
        c1 = c + d1;
        b1 = b ^ c1; b1 = {b1[11:0], b1[31:12]};
        a1 = a1 + b1 + y;
        d1 = d1 ^ a1; d1 = {d1[7:0], d1[31:8]};
        c1 = c1 + d1;
        b1 = b1 ^ c1; b1 = {b1[6:0], b1[31:7]};
        return {d1, c1, b1, a1};
    endfunction

    always_comb
    begin
        logic [127:0] g0, g1, g2, g3;
        v_next     = v_reg;
        m_next     = m_reg;
        round_next = round_reg;
        half_next  = half_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        g0 = '0; g1 = '0; g2 = '0; g3 = '0;
        if (req.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_next[i] = iv_word(3'(i));
            end
            for (int i = 0; i < 4; i++)
            begin
                v_next[8 + i] = iv_word(3'(i));
            end
            v_next[12] = '0;
            v_next[13] = '0;
            v_next[14] = req.block_len;
            v_next[15] = FLAGS_ROOT;
            for (int i = 0; i < 16; i++)
            begin
                m_next[i] = req.msg[32 * i +: 32];
            end
            round_next = '0;
            half_next  = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!half_reg)
            begin
                g0 = gmix(v_reg[0], v_reg[4], v_reg[8],  v_reg[12], m_reg[0], m_reg[1]);
                g1 = gmix(v_reg[1], v_reg[5], v_reg[9],  v_reg[13], m_reg[2], m_reg[3]);
                g2 = gmix(v_reg[2], v_reg[6], v_reg[10], v_reg[14], m_reg[4], m_reg[5]);
                g3 = gmix(v_reg[3], v_reg[7], v_reg[11], v_reg[15], m_reg[6], m_reg[7]);
                {v_next[12], v_next[8],  v_next[4], v_next[0]} = g0;
                {v_next[13], v_next[9],  v_next[5], v_next[1]} = g1;
                {v_next[14], v_next[10], v_next[6], v_next[2]} = g2;
                {v_next[15], v_next[11], v_next[7], v_next[3]} = g3;
                half_next = 1'b1;
            end
            else
            begin
                g0 = gmix(v_reg[0], v_reg[5], v_reg[10], v_reg[15], m_reg[8],  m_reg[9]);
                g1 = gmix(v_reg[1], v_reg[6], v_reg[11], v_reg[12], m_reg[10], m_reg[11]);
                g2 = gmix(v_reg[2], v_reg[7], v_reg[8],  v_reg[13], m_reg[12], m_reg[13]);
                g3 = gmix(v_reg[3], v_reg[4], v_reg[9],  v_reg[14], m_reg[14], m_reg[15]);
                {v_next[15], v_next[10], v_next[5], v_next[0]} = g0;
                {v_next[12], v_next[11], v_next[6], v_next[1]} = g1;
                {v_next[13], v_next[8],  v_next[7], v_next[2]} = g2;
                {v_next[14], v_next[9],  v_next[4], v_next[3]} = g3;
                for (int i = 0; i < 16; i++)
                begin
                    m_next[i] = m_reg[perm_idx(4'(i))];
                end
                half_next = 1'b0;
                if (round_reg == 3'(ROUNDS - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    round_next = round_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        m_reg <= m_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        for (int i = 0; i < 8; i++)
        begin
            rsp.digest[32 * i +: 32] = v_reg[i] ^ v_reg[i + 8];
        end
    end

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_done_ends_busy, clk, rst_n, done_next, !busy_reg)
    `ASSERT_IMPLIES(a_no_start_busy, clk, rst_n, busy_reg && !req.start, !done_reg || !busy_reg)
    `ASSERT_IMPLIES(a_half_only_busy, clk, rst_n, half_reg, busy_reg)
endmodule

// ===== dv/merkle_tree_proof_engine_tb.sv =====
// Self-checking testbench for the Merkle tree proof engine: build, prove and verify traffic
`timescale 1ns / 1ps
module merkle_tree_proof_engine_tb;
    import mtpe_pkg::*;

    localparam int unsigned LEAVES = 1024;
    localparam int unsigned NODES = 2 * LEAVES - 1;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned SETTLE = 100;

    typedef struct {
        logic [63:0] word;
        logic        last;
        logic        ok;
    } hash_beat_t;

    class merkle_scoreboard;
        logic [63:0]  seed [4];
        logic [255:0] tree [NODES];
        logic [255:0] running;
        logic [63:0]  sib_words [4];
        int unsigned  position;
        int unsigned  word_cnt;
        bit           in_proof;
        logic [31:0]  v [16];
        hash_beat_t   pending_beats [$];
        int unsigned  errors;

        function new();
            for (int i = 0; i < 4; i++)
            begin
                seed[i] = '0;
                sib_words[i] = '0;
            end
            running = '0;
            position = 0;
            word_cnt = 0;
            in_proof = 0;
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void g(int a, int b, int c, int d, logic [31:0] x, logic [31:0] y);
            v[a] = v[a] + v[b] + x;
            v[d] = rotr(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 12);
            v[a] = v[a] + v[b] + y;
            v[d] = rotr(v[d] ^ v[a], 8);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 7);
        endfunction

        function logic [255:0] blake3_block(logic [511:0] msg, logic [31:0] len);
            logic [31:0]  m [16];
            logic [31:0]  t [16];
            logic [31:0]  ivs [8];
            logic [255:0] d;
            ivs = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
            for (int i = 0; i < 16; i++)
                m[i] = msg[32 * i +: 32];
            for (int i = 0; i < 8; i++)
                v[i] = ivs[i];
            for (int i = 0; i < 4; i++)
                v[8 + i] = ivs[i];
            v[12] = '0;
            v[13] = '0;
            v[14] = len;
            v[15] = 32'd11;
            for (int r = 0; r < 7; r++)
            begin
                g(0, 4, 8, 12, m[0], m[1]);
                g(1, 5, 9, 13, m[2], m[3]);
                g(2, 6, 10, 14, m[4], m[5]);
                g(3, 7, 11, 15, m[6], m[7]);
                g(0, 5, 10, 15, m[8], m[9]);
                g(1, 6, 11, 12, m[10], m[11]);
                g(2, 7, 8, 13, m[12], m[13]);
                g(3, 4, 9, 14, m[14], m[15]);
                t = '{m[2], m[6], m[3], m[10], m[7], m[0], m[4], m[13],
                      m[1], m[11], m[12], m[5], m[9], m[14], m[15], m[8]};
                m = t;
            end
            for (int i = 0; i < 4; i++)
                d[64 * i +: 64] = {v[2 * i + 1] ^ v[2 * i + 9], v[2 * i] ^ v[2 * i + 8]};
            return d;
        endfunction

        function logic [255:0] leaf_hash(int unsigned leaf);
            logic [511:0] msg;
            msg = '0;
            msg[255:0] = {seed[3], seed[2], seed[1], seed[0]};
            msg[287:256] = leaf;
            return blake3_block(msg, LEN_LEAF);
        endfunction

        function logic [255:0] pair_hash(logic [255:0] l, logic [255:0] r);
            return blake3_block({r, l}, LEN_PAIR);
        endfunction

        function void expect_beat(logic [63:0] word, logic last, logic ok);
            hash_beat_t b;
            b.word = word;
            b.last = last;
            b.ok = ok;
            pending_beats.push_back(b);
        endfunction

        function void note_input(action_t act, logic [9:0] leaf, logic [63:0] word,
                                 logic last);
            int unsigned node;
            int unsigned sib;
            case (act)
                ACT_BUILD:
                begin
                    for (int i = 0; i < LEAVES; i++)
                        tree[LEAVES - 1 + i] = leaf_hash(i);
                    for (int i = LEAVES - 2; i >= 0; i--)
                        tree[i] = pair_hash(tree[2 * i + 1], tree[2 * i + 2]);
                    for (int k = 0; k < 4; k++)
                        expect_beat(tree[0][64 * k +: 64], k == 3, 1'b0);
                end
                ACT_PROVE:
                begin
                    node = LEAVES - 1 + leaf;
                    while (node > 0)
                    begin
                        sib = node[0] ? node + 1 : node - 1;
                        node = (node - 1) / 2;
                        for (int k = 0; k < 4; k++)
                            expect_beat(tree[sib][64 * k +: 64], node == 0 && k == 3, 1'b0);
                    end
                end
                ACT_VERIFY:
                begin
                    if (!in_proof)
                    begin
                        running = leaf_hash(leaf);
                        position = LEAVES - 1 + leaf;
                        word_cnt = 0;
                        in_proof = 1;
                    end
                    sib_words[word_cnt] = word;
                    word_cnt = (word_cnt + 1) % 4;
                    if (word_cnt == 0)
                    begin
                        if (position % 2 == 1)
                            running = pair_hash(running, {sib_words[3], sib_words[2],
                                                          sib_words[1], sib_words[0]});
                        else
                            running = pair_hash({sib_words[3], sib_words[2],
                                                 sib_words[1], sib_words[0]}, running);
                        if (position > 0)
                            position = (position - 1) / 2;
                    end
                    if (last)
                    begin
                        expect_beat(64'd0, 1'b1, running == tree[0]);
                        in_proof = 0;
                        word_cnt = 0;
                    end
                end
                default:;
            endcase
        endfunction

        function void check_beat(logic [63:0] word, logic last, logic ok);
            hash_beat_t b;
            if (pending_beats.size() == 0)
            begin
                report($sformatf("unexpected beat word=%h last=%b ok=%b", word, last, ok));
                return;
            end
            b = pending_beats.pop_front();
            if (word !== b.word)
                report($sformatf("out_word %h, want %h", word, b.word));
            if (last !== b.last)
                report($sformatf("out_last %b, want %b", last, b.last));
            if (ok !== b.ok)
                report($sformatf("proof_ok %b, want %b", ok, b.ok));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // action, leaf_index, proof_word, zero fill
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // out_word
    logic        m_axis_tuser;   // proof_ok
    logic        m_axis_tlast;

    merkle_scoreboard sb;
    int unsigned src_idle;
    int unsigned sink_idle;
    int unsigned items_sent;
    int unsigned cycles;
    bit          hold_req;
    bit          hold_taken;
    int unsigned hold_left;

    merkle_tree_proof_engine #(.LEAF_COUNT(LEAVES)) dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL merkle_tree_proof_engine");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        if (hold_req && !hold_taken && hold_left == 0)
        begin
            hold_left = 400;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end

    task automatic reg_write(int unsigned idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 8);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.seed[idx] = value;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_item(action_t act, logic [9:0] leaf, logic [63:0] word, logic last);
        if ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, word, leaf, act};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(act, leaf, word, last);
        items_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // variants: 0 good, 1 corrupted word, 2 truncated, 3 extra siblings past root,
    // 4 path of another leaf
    task automatic send_proof(logic [9:0] leaf, int variant, bit interleave);
        logic [63:0] words [$];
        int unsigned node;
        int unsigned sib;
        int unsigned cut;
        node = LEAVES - 1 + ((variant == 4) ? leaf + 1 : leaf) % LEAVES;
        while (node > 0)
        begin
            sib = node[0] ? node + 1 : node - 1;
            for (int k = 0; k < 4; k++)
                words.push_back(sb.tree[sib][64 * k +: 64]);
            node = (node - 1) / 2;
        end
        case (variant)
            1:
            begin
                cut = $urandom_range(words.size() - 1);
                words[cut] = words[cut] ^ (64'd1 << $urandom_range(63));
            end
            2:
                words = words[0:$urandom_range(words.size() - 2)];
            3:
                repeat (4 * $urandom_range(1, 2)) words.push_back(rand64());
            default:;
        endcase
        foreach (words[k])
        begin
            push_item(ACT_VERIFY, leaf, words[k], k == words.size() - 1);
            if (interleave && k == 1)
                push_item(ACT_PROVE, $urandom_range(1023), rand64(), $urandom_range(1));
        end
    endtask

    initial
    begin
        logic [63:0] seed_set [4];
        int unsigned r;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        src_idle = 7;
        sink_idle = 72;
        items_sent = 0;
        cycles = 0;
        hold_req = 0;
        hold_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 4; i++)
            reg_write(i, '1);
        push_item(ACT_BUILD, 10'd0, '0, 1'b0);
        push_item(ACT_PROVE, 10'd0, '1, 1'b1);
        push_item(ACT_PROVE, 10'd1023, '0, 1'b0);
        push_item(ACT_PROVE, 10'd512, rand64(), 1'b0);
        push_item(ACT_NONE, 10'd1023, '1, 1'b1);
        push_item(ACT_VERIFY, 10'd0, '1, 1'b1);
        push_item(ACT_VERIFY, 10'd1023, 64'd0, 1'b0);
        push_item(ACT_VERIFY, 10'd1023, '1, 1'b0);
        push_item(ACT_VERIFY, 10'd1023, 64'h0123456789abcdef, 1'b0);
        push_item(ACT_VERIFY, 10'd1023, 64'h8000000000000001, 1'b1);
        push_item(ACT_VERIFY, 10'd341, '0, 1'b0);
        push_item(ACT_BUILD, 10'd341, '0, 1'b1);
        push_item(ACT_VERIFY, 10'd341, '0, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            drain();
            src_idle = (p == 0) ? 7 : (p == 1) ? 72 : 0;
            sink_idle = (p == 0) ? 72 : (p == 1) ? 7 : 0;
            for (int i = 0; i < 4; i++)
                seed_set[i] = (p == 1) ? 64'd0 : rand64();
            for (int i = 0; i < 4; i++)
                reg_write(i, seed_set[i]);
            push_item(ACT_BUILD, $urandom_range(1023), rand64(), $urandom_range(1));
            if (p == 2)
            begin
                hold_req = 1;
                repeat (30) push_item(ACT_PROVE, $urandom_range(1023), rand64(), 1'b0);
                hold_req = 0;
            end
            while (items_sent < 120 * (p + 1))
            begin
                r = $urandom_range(99);
                if (r < 45)
                    send_proof($urandom_range(1023), $urandom_range(4), $urandom_range(7) == 0);
                else if (r < 75)
                    push_item(ACT_PROVE, $urandom_range(1023), rand64(), $urandom_range(1));
                else if (r < 85)
                    push_item(ACT_NONE, $urandom_range(1023), rand64(), $urandom_range(1));
                else
                begin
                    repeat ($urandom_range(0, 6))
                        push_item(ACT_VERIFY, $urandom_range(1023), rand64(), 1'b0);
                    push_item(ACT_VERIFY, $urandom_range(1023), rand64(), 1'b1);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("PASS merkle_tree_proof_engine");
        else
            $display("FAIL merkle_tree_proof_engine");
        $finish;
    end
endmodule
